// ===== design/parity_bit_framer_core_defines.svh =====
// assertion macros shared by the framer modules
// no dependencies; the asserting files pull this in by include
`ifndef PARITY_BIT_FRAMER_CORE_DEFINES_SVH
`define PARITY_BIT_FRAMER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define PBF_ASSERT_ALWAYS(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("pbf assertion failed");
`define PBF_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pbf assertion failed");
`define PBF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pbf assertion failed");
`else
`define PBF_ASSERT_ALWAYS(label, clk, rstn, prop)
`define PBF_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define PBF_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== design/pbf_pkg.sv =====
// types and constants for the parity bit framer
// no dependencies
package pbf_pkg;

    localparam int BYTE_BITS       = 8;
    localparam int GROUP_BITS      = BYTE_BITS + 1;
    localparam int MAX_FRAME_BYTES = 256;
    localparam int COUNT_W         = 12;
    localparam int COUNT_MAX       = (1 << COUNT_W) - 1;
    localparam int COUNT_LIMIT     = (MAX_FRAME_BYTES * GROUP_BITS > COUNT_MAX) ?
                                     COUNT_MAX : MAX_FRAME_BYTES * GROUP_BITS;

    typedef enum logic {
        DIR_PACK   = 1'b0,
        DIR_UNPACK = 1'b1
    } dir_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       parity_in;
        logic [3:0] valid_bits;
        logic       last_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               parity_out;
        logic [3:0]         out_bits;
        logic               short_frame;
        logic               length_error;
        logic [COUNT_W-1:0] total_bits;
        logic               last_out;
    } res_t;

    typedef struct packed {
        res_t       res0;
        res_t       res1;
        logic [1:0] num;
    } pair_t;

endpackage

// ===== design/parity_bit_framer_core.sv =====
// parity bit framer top level: input register, framer logic, result queue
// depends on pbf_pkg, pbf_in_reg, pbf_framer, pbf_out_queue
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    in_byte, parity_in, valid_bits, last_in
//  m_       out        m_valid / m_ready    out_byte .. last_out (seven fields)
//  cfg_     in         cfg_valid/cfg_ready  direction (0 pack, 1 unpack)
//
// the single result port drains the two-entry result queue, so an item with two
// results holds off the next item until only one is left and m_ready is high
// an item passes the input register and then the result queue on its way to m_
// reset clears the item and result flags, the frame state and direction (pack)
// a direction write drops any frame in progress; cfg_ready is always high
module parity_bit_framer_core import pbf_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_in_byte,
    input  logic               s_parity_in,
    input  logic [3:0]         s_valid_bits,
    input  logic               s_last_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_parity_out,
    output logic [3:0]         m_out_bits,
    output logic               m_short_frame,
    output logic               m_length_error,
    output logic [COUNT_W-1:0] m_total_bits,
    output logic               m_last_out,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_direction
);

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     item_take;
    logic     load_ready;
    logic     pair_load;
    pair_t    pair;
    res_t     m_res;

    assign cfg_ready = 1'b1;

    assign s_item.in_byte    = s_in_byte;
    assign s_item.parity_in  = s_parity_in;
    assign s_item.valid_bits = s_valid_bits;
    assign s_item.last_in    = s_last_in;

    pbf_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    pbf_framer u_framer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr        (cfg_valid && cfg_ready),
        .cfg_direction (cfg_direction),
        .item_valid    (item_valid),
        .item          (item),
        .item_take     (item_take),
        .load_ready    (load_ready),
        .pair_load     (pair_load),
        .pair          (pair)
    );

    pbf_out_queue u_out_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pair_load  (pair_load),
        .pair       (pair),
        .load_ready (load_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res      (m_res)
    );

    assign m_out_byte     = m_res.out_byte;
    assign m_parity_out   = m_res.parity_out;
    assign m_out_bits     = m_res.out_bits;
    assign m_short_frame  = m_res.short_frame;
    assign m_length_error = m_res.length_error;
    assign m_total_bits   = m_res.total_bits;
    assign m_last_out     = m_res.last_out;

endmodule

// ===== design/pbf_in_reg.sv =====
// input register for one item
// depends on pbf_pkg
module pbf_in_reg import pbf_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    output logic     item_valid,
    input  logic     item_take,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_ready    = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (item_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== design/pbf_framer.sv =====
// bit gearbox: frame state, pack and unpack logic, up to two results per item
// depends on pbf_pkg and the assertion macros
`include "parity_bit_framer_core_defines.svh"

module pbf_framer import pbf_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     cfg_wr,
    input  logic     cfg_direction,
    input  logic     item_valid,
    input  in_item_t item,
    output logic     item_take,
    input  logic     load_ready,
    output logic     pair_load,
    output pair_t    pair
);

    dir_t               dir_reg;
    logic [7:0]         acc_reg;
    logic [7:0]         acc_next;
    logic [3:0]         fill_reg;
    logic [3:0]         fill_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] base,
                                                   input logic [3:0] inc);
        logic [COUNT_W:0] sum;
        sum = {1'b0, base} + (COUNT_W+1)'(inc);
        if (sum > (COUNT_W+1)'(COUNT_LIMIT)) begin
            return COUNT_W'(COUNT_LIMIT);
        end
        return sum[COUNT_W-1:0];
    endfunction

    assign item_take = item_valid && load_ready;
    assign pair_load = item_take;

    always_comb begin
        logic [15:0]        word;
        logic [COUNT_W-1:0] cnt;
        logic [3:0]         v;
        logic [7:0]         mb;
        logic [4:0]         nf;
        logic [7:0]         rem;
        logic [3:0]         rem_fill;

        pair       = '0;
        acc_next   = acc_reg;
        fill_next  = fill_reg;
        count_next = count_reg;
        word       = '0;
        cnt        = '0;
        v          = 4'd8;
        mb         = '0;
        nf         = '0;
        rem        = '0;
        rem_fill   = '0;

        case (dir_reg)
            DIR_PACK: begin
                word = ({7'd0, item.parity_in, item.in_byte} << fill_reg[2:0])
                       | {8'd0, acc_reg};
                cnt  = sat_add(count_reg, 4'(GROUP_BITS));
                count_next = cnt;
                pair.res0.out_byte = word[7:0];
                pair.res0.out_bits = 4'd8;
                if (fill_reg[2:0] == 3'd7) begin
                    pair.res1.out_byte   = word[15:8];
                    pair.res1.out_bits   = 4'd8;
                    pair.res1.total_bits = item.last_in ? cnt : '0;
                    pair.res1.last_out   = item.last_in;
                    pair.num  = 2'd2;
                    acc_next  = '0;
                    fill_next = '0;
                end else if (item.last_in) begin
                    pair.res1.out_byte   = word[15:8];
                    pair.res1.out_bits   = {1'b0, fill_reg[2:0]} + 4'd1;
                    pair.res1.total_bits = cnt;
                    pair.res1.last_out   = 1'b1;
                    pair.num = 2'd2;
                end else begin
                    pair.num  = 2'd1;
                    acc_next  = word[15:8];
                    fill_next = {1'b0, fill_reg[2:0]} + 4'd1;
                end
            end
            DIR_UNPACK: begin
                if (item.last_in && item.valid_bits >= 4'd1 && item.valid_bits <= 4'd8) begin
                    v = item.valid_bits;
                end
                for (int i = 0; i < 8; i++) begin
                    mb[i] = item.in_byte[i] & (4'(i) < v);
                end
                cnt = sat_add(count_reg, v);
                count_next = cnt;
                if (item.last_in && count_reg == '0 && fill_reg == '0) begin
                    pair.res0.out_byte    = mb;
                    pair.res0.out_bits    = v;
                    pair.res0.short_frame = 1'b1;
                    pair.res0.total_bits  = cnt;
                    pair.res0.last_out    = 1'b1;
                    pair.num = 2'd1;
                end else begin
                    word = ({8'd0, mb} << fill_reg) | {8'd0, acc_reg};
                    nf   = {1'b0, fill_reg} + {1'b0, v};
                    if (nf >= 5'(GROUP_BITS)) begin
                        pair.res0.out_byte   = word[7:0];
                        pair.res0.parity_out = word[8];
                        pair.res0.out_bits   = 4'd8;
                        if (item.last_in && nf == 5'(GROUP_BITS)) begin
                            pair.res0.total_bits = cnt;
                            pair.res0.last_out   = 1'b1;
                        end
                        rem      = {1'b0, word[15:9]};
                        rem_fill = 4'(nf - 5'(GROUP_BITS));
                    end else begin
                        rem      = word[7:0];
                        rem_fill = nf[3:0];
                    end
                    if (item.last_in && rem_fill != '0) begin
                        if (nf >= 5'(GROUP_BITS)) begin
                            pair.res1.out_byte     = rem;
                            pair.res1.out_bits     = rem_fill;
                            pair.res1.length_error = 1'b1;
                            pair.res1.total_bits   = cnt;
                            pair.res1.last_out     = 1'b1;
                            pair.num = 2'd2;
                        end else begin
                            pair.res0.out_byte     = rem;
                            pair.res0.out_bits     = rem_fill;
                            pair.res0.length_error = 1'b1;
                            pair.res0.total_bits   = cnt;
                            pair.res0.last_out     = 1'b1;
                            pair.num = 2'd1;
                        end
                    end else begin
                        pair.num = (nf >= 5'(GROUP_BITS)) ? 2'd1 : 2'd0;
                    end
                    acc_next  = rem;
                    fill_next = rem_fill;
                end
            end
            default: begin
                pair = '0;
            end
        endcase

        // end of frame drops all pending state
        if (item.last_in) begin
            acc_next   = '0;
            fill_next  = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg   <= DIR_PACK;
            acc_reg   <= '0;
            fill_reg  <= '0;
            count_reg <= '0;
        end else if (cfg_wr) begin
            dir_reg   <= dir_t'(cfg_direction);
            acc_reg   <= '0;
            fill_reg  <= '0;
            count_reg <= '0;
        end else if (pair_load) begin
            acc_reg   <= acc_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
        end
    end

    `PBF_ASSERT_ALWAYS(a_count_limit, aclk, aresetn, count_reg <= COUNT_W'(COUNT_LIMIT))
    `PBF_ASSERT_ALWAYS(a_fill_range, aclk, aresetn, fill_reg <= 4'd8)
    `PBF_ASSERT_IMPLIES(a_pack_fill, aclk, aresetn, dir_reg == DIR_PACK, fill_reg <= 4'd7)
    `PBF_ASSERT_NEXT(a_frame_end_clear, aclk, aresetn, pair_load && item.last_in, count_reg == '0 && fill_reg == '0)
    `PBF_ASSERT_IMPLIES(a_pair_order, aclk, aresetn, pair_load && pair.num == 2'd2, !pair.res0.last_out)

endmodule

// ===== design/pbf_out_queue.sv =====
// two-entry result register feeding the output channel
// depends on pbf_pkg and the assertion macros
`include "parity_bit_framer_core_defines.svh"

module pbf_out_queue import pbf_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  pair_load,
    input  pair_t pair,
    output logic  load_ready,
    output logic  m_valid,
    input  logic  m_ready,
    output res_t  m_res
);

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    res_t       slot0_reg;
    res_t       slot1_reg;
    logic       pop;

    assign m_valid    = cnt_reg != 2'd0;
    assign m_res      = slot0_reg;
    assign pop        = m_valid && m_ready;
    assign load_ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);

    always_comb begin
        cnt_next = cnt_reg;
        if (pair_load) begin
            cnt_next = pair.num;
        end else if (pop) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pair_load) begin
            slot0_reg <= pair.res0;
            slot1_reg <= pair.res1;
        end else if (pop) begin
            slot0_reg <= slot1_reg;
        end
    end

    `PBF_ASSERT_ALWAYS(a_cnt_range, aclk, aresetn, cnt_reg != 2'd3)
    `PBF_ASSERT_IMPLIES(a_first_not_last, aclk, aresetn, cnt_reg == 2'd2, !slot0_reg.last_out)
    `PBF_ASSERT_NEXT(a_drain_step, aclk, aresetn, cnt_reg == 2'd2 && m_ready, cnt_reg == 2'd1)

endmodule
